@@ src/assert_macros.svh @@
// assertion macros used by the circumcircle top level rtl
// no dependencies; assumes clk and rst_n in scope for TPC_ASSERT
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TPC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tpc assertion failed");
`define TPC_ASSERT_CLK(label, ck, rn, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("tpc assertion failed");
`else
`define TPC_ASSERT(label, prop)
`define TPC_ASSERT_CLK(label, ck, rn, prop)
`endif
`endif

@@ src/tpc_pkg.sv @@
// types and fixed widths for the three point circumcircle pipeline
// no dependencies
package tpc_pkg;

    localparam int CENTER_W   = 32;
    localparam int RADIUS_W   = 31;
    localparam int ROOT_W     = 32;
    localparam int RAD_W      = 64;
    localparam int OUT_DATA_W = 96;

    localparam logic [32:0] CENTER_POS_LIM = 33'h0_7FFF_FFFF;
    localparam logic [32:0] CENTER_NEG_LIM = 33'h0_8000_0000;

    typedef enum logic [1:0] {
        STATUS_VALID     = 2'd0,
        STATUS_COLLINEAR = 2'd1,
        STATUS_SATURATED = 2'd2
    } status_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic collinear;
    } sign_t;

    typedef struct packed {
        logic collinear;
        logic saturated;
    } flags_t;

    typedef struct packed {
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        flags_t                     flags;
    } centre_t;

endpackage

@@ src/tpc_front.sv @@
// front end: norms, differences, numerators and determinant, divider operands
// depends on tpc_pkg
module tpc_front
    import tpc_pkg::*;
#(
    parameter int COORD_BITS = 11,
    parameter int FRAC_BITS  = 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [COORD_BITS-1:0]        x1,
    input  logic [COORD_BITS-1:0]        y1,
    input  logic [COORD_BITS-1:0]        x2,
    input  logic [COORD_BITS-1:0]        y2,
    input  logic [COORD_BITS-1:0]        x3,
    input  logic [COORD_BITS-1:0]        y3,
    output logic                         out_valid,
    output logic [3*COORD_BITS+FRAC_BITS+5:0] num_x,
    output logic [3*COORD_BITS+FRAC_BITS+5:0] num_y,
    output logic [2*COORD_BITS+3:0]      den,
    output sign_t                        sign,
    output logic [COORD_BITS-1:0]        out_x1,
    output logic [COORD_BITS-1:0]        out_y1
);

    localparam int C   = COORD_BITS;
    localparam int NW  = 2 * C + 1;
    localparam int PW  = NW + C + 2;
    localparam int NXW = PW + 2;
    localparam int DPW = 2 * C + 2;
    localparam int DW  = DPW + 1;
    localparam int QW  = NXW + FRAC_BITS + 1;

    // stage 1: norms and differences
    logic                v1_reg;
    logic [NW-1:0]       n1_reg, n2_reg, n3_reg;
    logic signed [C:0]   dx21_reg, dx31_reg, dx32_reg, dy21_reg, dy31_reg, dy32_reg;
    logic [C-1:0]        x1a_reg, y1a_reg;
    // stage 2: products
    logic                v2_reg;
    logic signed [PW-1:0]  pnx1_reg, pnx2_reg, pnx3_reg, pny1_reg, pny2_reg, pny3_reg;
    logic signed [DPW-1:0] pd1_reg, pd2_reg;
    logic [C-1:0]        x1b_reg, y1b_reg;
    // stage 3: sums
    logic                v3_reg;
    logic signed [NXW-1:0] nx_reg, ny_reg;
    logic signed [DW-1:0]  det_reg;
    logic [C-1:0]        x1c_reg, y1c_reg;
    // stage 4: divider operands
    logic                v4_reg;
    logic [QW-1:0]       numx_reg, numy_reg;
    logic [DW:0]         den_reg;
    sign_t               sign_reg;
    logic [C-1:0]        x1d_reg, y1d_reg;

    logic [NXW-1:0]      absnx_next, absny_next;
    logic [DW-1:0]       absdet_next;

    always_comb
    begin
        absnx_next  = nx_reg[NXW-1] ? NXW'(-nx_reg) : NXW'(nx_reg);
        absny_next  = ny_reg[NXW-1] ? NXW'(-ny_reg) : NXW'(ny_reg);
        absdet_next = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= NW'(x1) * NW'(x1) + NW'(y1) * NW'(y1);
            n2_reg   <= NW'(x2) * NW'(x2) + NW'(y2) * NW'(y2);
            n3_reg   <= NW'(x3) * NW'(x3) + NW'(y3) * NW'(y3);
            dx21_reg <= $signed({1'b0, x2}) - $signed({1'b0, x1});
            dx31_reg <= $signed({1'b0, x3}) - $signed({1'b0, x1});
            dx32_reg <= $signed({1'b0, x3}) - $signed({1'b0, x2});
            dy21_reg <= $signed({1'b0, y2}) - $signed({1'b0, y1});
            dy31_reg <= $signed({1'b0, y3}) - $signed({1'b0, y1});
            dy32_reg <= $signed({1'b0, y3}) - $signed({1'b0, y2});
            x1a_reg  <= x1;
            y1a_reg  <= y1;

            pnx1_reg <= $signed({1'b0, n1_reg}) * dy32_reg;
            pnx2_reg <= $signed({1'b0, n2_reg}) * dy31_reg;
            pnx3_reg <= $signed({1'b0, n3_reg}) * dy21_reg;
            pny1_reg <= $signed({1'b0, n1_reg}) * dx32_reg;
            pny2_reg <= $signed({1'b0, n2_reg}) * dx31_reg;
            pny3_reg <= $signed({1'b0, n3_reg}) * dx21_reg;
            pd1_reg  <= dx21_reg * dy31_reg;
            pd2_reg  <= dx31_reg * dy21_reg;
            x1b_reg  <= x1a_reg;
            y1b_reg  <= y1a_reg;

            // nx = -n1*dy32 + n2*dy31 - n3*dy21, ny = n1*dx32 - n2*dx31 + n3*dx21
            nx_reg  <= NXW'(pnx2_reg) - NXW'(pnx1_reg) - NXW'(pnx3_reg);
            ny_reg  <= NXW'(pny1_reg) - NXW'(pny2_reg) + NXW'(pny3_reg);
            det_reg <= DW'(pd1_reg) - DW'(pd2_reg);
            x1c_reg <= x1b_reg;
            y1c_reg <= y1b_reg;

            // round to nearest: (|n|*2^f + |d|) / (2|d|)
            numx_reg <= (QW'(absnx_next) << FRAC_BITS) + QW'(absdet_next);
            numy_reg <= (QW'(absny_next) << FRAC_BITS) + QW'(absdet_next);
            den_reg  <= {absdet_next, 1'b0};
            sign_reg.neg_x     <= nx_reg[NXW-1] ^ det_reg[DW-1];
            sign_reg.neg_y     <= ny_reg[NXW-1] ^ det_reg[DW-1];
            sign_reg.collinear <= (det_reg == '0);
            x1d_reg  <= x1c_reg;
            y1d_reg  <= y1c_reg;
        end
    end

    assign out_valid = v4_reg;
    assign num_x     = numx_reg;
    assign num_y     = numy_reg;
    assign den       = den_reg;
    assign sign      = sign_reg;
    assign out_x1    = x1d_reg;
    assign out_y1    = y1d_reg;

endmodule

@@ src/tpc_div.sv @@
// pipelined restoring divider, two numerators over one shared divisor
// one quotient bit per stage; no package dependency
module tpc_div
#(
    parameter int NUM_W  = 42,
    parameter int DEN_W  = 26,
    parameter int SIDE_W = 25
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num_x,
    input  logic [NUM_W-1:0]  num_y,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quo_x,
    output logic [NUM_W-1:0]  quo_y,
    output logic [SIDE_W-1:0] out_side
);

    logic              v_reg  [NUM_W];
    logic [DEN_W-1:0]  rx_reg [NUM_W];
    logic [DEN_W-1:0]  ry_reg [NUM_W];
    logic [DEN_W-1:0]  d_reg  [NUM_W];
    logic [NUM_W-1:0]  qx_reg [NUM_W];
    logic [NUM_W-1:0]  qy_reg [NUM_W];
    logic [SIDE_W-1:0] s_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic              v_src;
        logic [DEN_W-1:0]  rx_src, ry_src, d_src;
        logic [NUM_W-1:0]  qx_src, qy_src;
        logic [SIDE_W-1:0] s_src;
        logic [DEN_W:0]    tx, ty;
        logic              gex, gey;
        logic [DEN_W-1:0]  rx_next, ry_next;

        if (k == 0)
        begin : g_first
            assign v_src  = in_valid;
            assign rx_src = '0;
            assign ry_src = '0;
            assign d_src  = den;
            assign qx_src = num_x;
            assign qy_src = num_y;
            assign s_src  = side;
        end
        else
        begin : g_next
            assign v_src  = v_reg[k-1];
            assign rx_src = rx_reg[k-1];
            assign ry_src = ry_reg[k-1];
            assign d_src  = d_reg[k-1];
            assign qx_src = qx_reg[k-1];
            assign qy_src = qy_reg[k-1];
            assign s_src  = s_reg[k-1];
        end

        // dividend bits leave at the top, quotient bits enter at the bottom
        assign tx  = {rx_src, qx_src[NUM_W-1]};
        assign ty  = {ry_src, qy_src[NUM_W-1]};
        assign gex = (tx >= {1'b0, d_src});
        assign gey = (ty >= {1'b0, d_src});
        assign rx_next = gex ? DEN_W'(tx - {1'b0, d_src}) : DEN_W'(tx);
        assign ry_next = gey ? DEN_W'(ty - {1'b0, d_src}) : DEN_W'(ty);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[k] <= rx_next;
                ry_reg[k] <= ry_next;
                d_reg[k]  <= d_src;
                qx_reg[k] <= {qx_src[NUM_W-2:0], gex};
                qy_reg[k] <= {qy_src[NUM_W-2:0], gey};
                s_reg[k]  <= s_src;
            end
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign quo_x     = qx_reg[NUM_W-1];
    assign quo_y     = qy_reg[NUM_W-1];
    assign out_side  = s_reg[NUM_W-1];

endmodule

@@ src/tpc_radius.sv @@
// radius: offset to the first point, squares, sum, then a pipelined square root
// depends on tpc_pkg
module tpc_radius
    import tpc_pkg::*;
#(
    parameter int COORD_BITS = 11,
    parameter int FRAC_BITS  = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  centre_t               centre,
    input  logic [COORD_BITS-1:0] x1,
    input  logic [COORD_BITS-1:0] y1,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     root,
    output centre_t               out_centre
);

    localparam int DXW = CENTER_W + 2;
    localparam int RW  = ROOT_W + 3;

    logic signed [DXW-1:0] dx_next, dy_next;
    logic                  r1_valid_reg, r2_valid_reg, r3_valid_reg;
    logic [CENTER_W-1:0]   ax_reg, ay_reg;
    logic [RAD_W-1:0]      sx_reg, sy_reg, sum_reg;
    centre_t               c1_reg, c2_reg, c3_reg;

    logic              q_valid_reg [ROOT_W];
    logic [RW-1:0]     rem_reg     [ROOT_W];
    logic [ROOT_W-1:0] root_reg    [ROOT_W];
    logic [RAD_W-1:0]  rad_reg     [ROOT_W];
    centre_t           cen_reg     [ROOT_W];

    always_comb
    begin
        dx_next = DXW'(centre.cx) - $signed(DXW'(x1) << FRAC_BITS);
        dy_next = DXW'(centre.cy) - $signed(DXW'(y1) << FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_valid_reg <= in_valid;
            r2_valid_reg <= r1_valid_reg;
            r3_valid_reg <= r2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // offsets stay below 2^32 in magnitude
            ax_reg  <= dx_next[DXW-1] ? CENTER_W'(-dx_next) : CENTER_W'(dx_next);
            ay_reg  <= dy_next[DXW-1] ? CENTER_W'(-dy_next) : CENTER_W'(dy_next);
            c1_reg  <= centre;
            sx_reg  <= RAD_W'(ax_reg) * RAD_W'(ax_reg);
            sy_reg  <= RAD_W'(ay_reg) * RAD_W'(ay_reg);
            c2_reg  <= c1_reg;
            sum_reg <= sx_reg + sy_reg;
            c3_reg  <= c2_reg;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        logic              v_src;
        logic [RW-1:0]     rem_src;
        logic [ROOT_W-1:0] root_src;
        logic [RAD_W-1:0]  rad_src;
        centre_t           cen_src;
        logic [RW-1:0]     trial, sub;
        logic              ge;
        logic [RW-1:0]     rem_next;

        if (k == 0)
        begin : g_first
            assign v_src    = r3_valid_reg;
            assign rem_src  = '0;
            assign root_src = '0;
            assign rad_src  = sum_reg;
            assign cen_src  = c3_reg;
        end
        else
        begin : g_next
            assign v_src    = q_valid_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign rad_src  = rad_reg[k-1];
            assign cen_src  = cen_reg[k-1];
        end

        // two radicand bits per stage
        assign trial    = {rem_src[RW-3:0], rad_src[RAD_W-1 -: 2]};
        assign sub      = RW'({root_src, 2'b01});
        assign ge       = (trial >= sub);
        assign rem_next = ge ? (trial - sub) : trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                q_valid_reg[k] <= 1'b0;
            else if (en)
                q_valid_reg[k] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= {root_src[ROOT_W-2:0], ge};
                rad_reg[k]  <= {rad_src[RAD_W-3:0], 2'b00};
                cen_reg[k]  <= cen_src;
            end
        end
    end

    assign out_valid  = q_valid_reg[ROOT_W-1];
    assign root       = root_reg[ROOT_W-1];
    assign out_centre = cen_reg[ROOT_W-1];

endmodule

@@ src/three_point_circumcircle.sv @@
// Circumcircle of three pixel points, one item per clock unless m_tready stalls.
// Input channel s_*: one item is six COORD_BITS coordinates (first, second,
// third point, x before y). Output channel m_*: centre x and y and radius in
// signed / unsigned fixed point with FRAC_BITS fraction bits, status on m_tuser
// (valid, collinear, saturated). Collinear points give zero centre and radius.
// Throughput: one item per cycle unless m_tready stalls the output. The path
// runs through 41 + QW register stages, where QW is the divider depth of
// 3*COORD_BITS + FRAC_BITS + 6: four front stages, one divider stage per
// quotient bit, one clamp stage, three offset and square stages, 32 square
// root stages, the output register.
// The whole pipeline moves together: it advances whenever the output register
// is empty or being taken, and freezes while the receiver holds m_tready low,
// so nothing is lost or repeated; s_tready drops in the same cycles.
// Reset clears all valid bits; no item is in flight afterwards and no clearing
// pass is needed. Depends on tpc_pkg, tpc_front, tpc_div, tpc_radius.
`include "assert_macros.svh"
module three_point_circumcircle
    import tpc_pkg::*;
#(
    parameter int COORD_BITS = 11,
    parameter int FRAC_BITS  = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y, zero pad
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // center_x, center_y, circle_radius, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // result_status
    output logic [1:0]            m_tuser
);

    localparam int C      = COORD_BITS;
    localparam int NXW    = 3 * C + 5;
    localparam int DW     = 2 * C + 3;
    localparam int QW     = NXW + FRAC_BITS + 1;
    localparam int DENW   = DW + 1;
    localparam int SIDE_W = 2 * C + $bits(sign_t);
    localparam int QXW    = (QW > 33) ? QW : 33;

    logic                en;
    logic                f_valid;
    logic [QW-1:0]       f_num_x, f_num_y;
    logic [DENW-1:0]     f_den;
    sign_t               f_sign;
    logic [C-1:0]        f_x1, f_y1;
    logic                d_valid;
    logic [QW-1:0]       d_quo_x, d_quo_y;
    logic [SIDE_W-1:0]   d_side;
    sign_t               d_sign;
    logic [C-1:0]        d_x1, d_y1;
    logic [32:0]         cx_next, cy_next;
    logic                p1_valid_reg;
    centre_t             p1_centre_reg;
    logic [C-1:0]        p1_x1_reg, p1_y1_reg;
    logic                r_valid;
    logic [ROOT_W-1:0]   r_root;
    centre_t             r_centre;
    logic                m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    status_t             m_tuser_reg, m_tuser_next;

    // {saturated, value}: round-to-nearest magnitude with sign, clamped to 32 bits
    function automatic logic [32:0] clamp_q(input logic [QXW-1:0] q, input logic neg);
        logic [32:0] res;
        if (neg)
        begin
            if (q > QXW'(CENTER_NEG_LIM))
                res = {1'b1, 32'h8000_0000};
            else
                res = {1'b0, 32'(-q[31:0])};
        end
        else
        begin
            if (q > QXW'(CENTER_POS_LIM))
                res = {1'b1, 32'h7FFF_FFFF};
            else
                res = {1'b0, q[31:0]};
        end
        return res;
    endfunction

    assign en       = m_tready || !m_tvalid_reg;
    assign s_tready = en;

    tpc_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .x1        (s_tdata[0*C +: C]),
        .y1        (s_tdata[1*C +: C]),
        .x2        (s_tdata[2*C +: C]),
        .y2        (s_tdata[3*C +: C]),
        .x3        (s_tdata[4*C +: C]),
        .y3        (s_tdata[5*C +: C]),
        .out_valid (f_valid),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .den       (f_den),
        .sign      (f_sign),
        .out_x1    (f_x1),
        .out_y1    (f_y1)
    );

    tpc_div #(
        .NUM_W  (QW),
        .DEN_W  (DENW),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .den       (f_den),
        .side      ({f_x1, f_y1, f_sign}),
        .out_valid (d_valid),
        .quo_x     (d_quo_x),
        .quo_y     (d_quo_y),
        .out_side  (d_side)
    );

    assign {d_x1, d_y1, d_sign} = d_side;

    always_comb
    begin
        cx_next = clamp_q(QXW'(d_quo_x), d_sign.neg_x);
        cy_next = clamp_q(QXW'(d_quo_y), d_sign.neg_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_centre_reg.cx              <= $signed(cx_next[31:0]);
            p1_centre_reg.cy              <= $signed(cy_next[31:0]);
            p1_centre_reg.flags.collinear <= d_sign.collinear;
            p1_centre_reg.flags.saturated <= cx_next[32] | cy_next[32];
            p1_x1_reg                     <= d_x1;
            p1_y1_reg                     <= d_y1;
        end
    end

    tpc_radius #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_radius (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (p1_valid_reg),
        .centre     (p1_centre_reg),
        .x1         (p1_x1_reg),
        .y1         (p1_y1_reg),
        .out_valid  (r_valid),
        .root       (r_root),
        .out_centre (r_centre)
    );

    always_comb
    begin
        m_tdata_next = '0;
        m_tuser_next = STATUS_VALID;
        if (r_centre.flags.collinear)
            m_tuser_next = STATUS_COLLINEAR;
        else
        begin
            m_tdata_next[31:0]  = r_centre.cx;
            m_tdata_next[63:32] = r_centre.cy;
            // a root of 2^31 or more clamps the radius
            m_tdata_next[94:64] = r_root[ROOT_W-1] ? {RADIUS_W{1'b1}}
                                                   : r_root[RADIUS_W-1:0];
            if (r_centre.flags.saturated || r_root[ROOT_W-1])
                m_tuser_next = STATUS_SATURATED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (en)
            m_tvalid_reg <= r_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `TPC_ASSERT(a_collinear_zero, (m_tvalid && m_tuser == STATUS_COLLINEAR) |-> (m_tdata == '0))
    `TPC_ASSERT(a_empty_ready, !m_tvalid |-> s_tready)
    `TPC_ASSERT_CLK(a_rise_after_advance, clk, rst_n, $rose(m_tvalid) |-> $past(s_tready))

endmodule

@@ tb/sv/tb_three_point_circumcircle.sv @@
// testbench for three_point_circumcircle: random and directed point triples,
// predicted circumcircle compared field by field against the output stream
// depends on tpc_pkg and the three_point_circumcircle rtl
module tb_three_point_circumcircle;
    import tpc_pkg::*;

    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 4;
    localparam int IN_W       = ((6*COORD_BITS+7)/8)*8;
    localparam int LATENCY    = 41 + 3*COORD_BITS + FRAC_BITS + 9;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        radius;
        status_t            status;
    } circle_t;

    class circle_board;
        circle_t pending[$];
        int      fails;

        // round(num * 2^FRAC_BITS / den), ties away from zero
        function longint fixed_div(longint num, longint den);
            longint unsigned n, d, q;
            bit neg;
            neg = (num < 0) != (den < 0);
            n = num < 0 ? -num : num;
            d = den < 0 ? -den : den;
            q = ((n << (FRAC_BITS + 1)) + d) / (2 * d);
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function longint clamp32(longint v, ref bit sat);
            if (v > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
            if (v < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
            return v;
        endfunction

        function longint unsigned root_down(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function void note_points(logic [IN_W-1:0] d);
            longint p[6];
            longint n1, n2, n3, det, nx, ny, cx, cy, dx, dy;
            longint unsigned ax, ay, sx, s, r;
            bit sat;
            circle_t c;
            for (int i = 0; i < 6; i++) p[i] = d[i*COORD_BITS +: COORD_BITS];
            sat = 0;
            n1 = p[0]*p[0] + p[1]*p[1];
            n2 = p[2]*p[2] + p[3]*p[3];
            n3 = p[4]*p[4] + p[5]*p[5];
            det = p[0]*(p[3]-p[5]) - p[1]*(p[2]-p[4]) + p[2]*p[5] - p[4]*p[3];
            if (det == 0)
            begin
                c.cx = 0; c.cy = 0; c.radius = 0; c.status = STATUS_COLLINEAR;
            end
            else
            begin
                nx = n1*(p[3]-p[5]) + n2*(p[5]-p[1]) + n3*(p[1]-p[3]);
                ny = n1*(p[4]-p[2]) + n2*(p[0]-p[4]) + n3*(p[2]-p[0]);
                cx = clamp32(fixed_div(nx, 2*det), sat);
                cy = clamp32(fixed_div(ny, 2*det), sat);
                dx = cx - (p[0] << FRAC_BITS);
                dy = cy - (p[1] << FRAC_BITS);
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                sx = ax*ax;
                s = sx + ay*ay;
                if (s < sx)
                begin
                    r = 64'h7FFF_FFFF; sat = 1;
                end
                else
                begin
                    r = root_down(s);
                    if (r > 64'h7FFF_FFFF) begin r = 64'h7FFF_FFFF; sat = 1; end
                end
                c.cx = cx[31:0]; c.cy = cy[31:0]; c.radius = r[30:0];
                c.status = sat ? STATUS_SATURATED : STATUS_VALID;
            end
            pending = {pending, c};
        endfunction

        function void check_circle(logic [OUT_DATA_W-1:0] d, logic [1:0] st);
            circle_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected");
                fails++;
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.cx)
            begin
                $error("center_x expected %0d actual %0d", e.cx, $signed(d[31:0])); fails++;
            end
            if (d[63:32] !== e.cy)
            begin
                $error("center_y expected %0d actual %0d", e.cy, $signed(d[63:32])); fails++;
            end
            if (d[94:64] !== e.radius)
            begin
                $error("circle_radius expected %0d actual %0d", e.radius, d[94:64]); fails++;
            end
            if (st !== e.status)
            begin
                $error("result_status expected %0d actual %0d", e.status, st); fails++;
            end
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    circle_board board = new();
    bit          calm;

    three_point_circumcircle #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) board.check_circle(m_tdata, m_tuser);
        m_tready <= calm || ($urandom_range(0, 99) >= 35);
    end

    // one item, holding tvalid until accepted
    task automatic send_points(input logic [COORD_BITS-1:0] p[6]);
        logic [IN_W-1:0] d;
        d = '0;
        for (int i = 0; i < 6; i++) d[i*COORD_BITS +: COORD_BITS] = p[i];
        while (!calm && $urandom_range(0, 99) < 35)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        board.note_points(d);
    endtask

    task automatic send_line(input int a, b, c, e, f, g);
        logic [COORD_BITS-1:0] p[6];
        p = '{COORD_BITS'(a), COORD_BITS'(b), COORD_BITS'(c),
              COORD_BITS'(e), COORD_BITS'(f), COORD_BITS'(g)};
        send_points(p);
    endtask

    initial
    begin
        logic [COORD_BITS-1:0] p[6];
        int m;
        m = (1 << COORD_BITS) - 1;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_line(0, 0, 0, 0, 0, 0);            // coincident
        send_line(0, 0, m, m, 5, 5);            // collinear diagonal
        send_line(0, 0, m, 0, 0, m);
        send_line(m, m, 0, m, m, 0);
        send_line(0, 0, 1, 0, 0, 1);
        send_line(0, 0, 2, 0, 1, 1);
        send_line(0, 0, 1, 1, m, m - 1);        // nearly collinear, large centre
        send_line(0, 0, 1, 0, m, 1);
        send_line(m, 0, 0, m, m, m);
        send_line(10, 20, 30, 20, 20, 30);
        send_line(0, m, m, m, m, m - 1);
        send_line(3, 3, 3, 3, 100, 200);        // two points the same
        send_line(1, 2, 3, 4, 5, 7);
        for (int i = 0; i < 550; i++)
        begin
            calm = (i >= 200 && i < 280);
            if (i == 300)
            begin
                // hold off until the pipeline has drained
                s_tvalid <= 0;
                wait (board.pending.size() == 0);
                @(posedge clk);
            end
            case ($urandom_range(0, 3))
                0: for (int k = 0; k < 6; k++) p[k] = COORD_BITS'($urandom);
                1:
                begin
                    // small clustered triangles
                    p[0] = COORD_BITS'($urandom); p[1] = COORD_BITS'($urandom);
                    for (int k = 2; k < 6; k++)
                        p[k] = COORD_BITS'(p[k & 1] + $urandom_range(0, 6) - 3);
                end
                2:
                begin
                    // collinear or near collinear
                    p[0] = COORD_BITS'($urandom_range(0, 600));
                    p[1] = COORD_BITS'($urandom_range(0, 600));
                    p[2] = COORD_BITS'(p[0] + 2); p[3] = COORD_BITS'(p[1] + 3);
                    p[4] = COORD_BITS'(p[0] + 4 * $urandom_range(1, 200));
                    p[5] = COORD_BITS'(p[1] + 6 * $urandom_range(1, 200) + $urandom_range(0, 1));
                end
                default:
                    for (int k = 0; k < 6; k++)
                        p[k] = $urandom_range(0, 1) ? COORD_BITS'(m) : '0;
            endcase
            send_points(p);
        end
        s_tvalid <= 0;
        calm = 0;
        wait (board.pending.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (board.fails == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+src
src/tpc_pkg.sv
src/tpc_front.sv
src/tpc_div.sv
src/tpc_radius.sv
src/three_point_circumcircle.sv
tb/sv/tb_three_point_circumcircle.sv
